FILE: hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

  localparam int unsigned ItemW = 27;
  localparam int unsigned ResW  = 14;

  // Configuration register indexes.
  localparam logic [1:0] CfgStartStop = 2'd0;
  localparam logic [1:0] CfgBitPhase  = 2'd1;
  localparam logic [1:0] CfgAckLimit  = 2'd2;

  // One input item; the first member is the most significant, so req sits at bit 0.
  typedef struct packed {
    logic       sda_in;
    logic [7:0] wr_data;
    logic [7:0] mem_addr;
    logic [7:0] dev_addr;
    logic       func;
    logic       req;
  } item_t;

  // One result item; scl_out sits at bit 0.
  typedef struct packed {
    logic       ack_error;
    logic [7:0] rd_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_out;
    logic       scl_out;
  } res_t;

  // Timing configuration seen by the bus engine.
  typedef struct packed {
    logic [7:0] start_stop_delay;
    logic [7:0] bit_phase_delay;
    logic [7:0] ack_limit;
  } cfg_t;

endpackage

FILE: hw/rtl/i2cm_engine.sv
// Bus sequencer: advances the I2C waveform by one tick for each item.
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_SEND_LO, PH_SEND_HI, PH_SEND_TAIL,
    PH_ACK_PREP, PH_ACK_HI, PH_ACK_POLL, PH_READ_LO, PH_READ_HI,
    PH_NACK_LO, PH_NACK_HI, PH_STOP_A, PH_STOP_END
  } phase_t;

  typedef enum logic [3:0] {
    OP_START, OP_SDEV, OP_SREG, OP_SDATA, OP_SDEV1, OP_ACK, OP_READ, OP_NACK, OP_STOP
  } op_t;

  // Transaction scripts: write and read, indexed by step.
  function automatic op_t script_op(input logic is_wr, input logic [3:0] idx);
    op_t op;
    op = OP_STOP;
    if (is_wr) begin
      unique case (idx)
        4'd0:    op = OP_START;
        4'd1:    op = OP_SDEV;
        4'd2:    op = OP_ACK;
        4'd3:    op = OP_SREG;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_SDATA;
        4'd6:    op = OP_ACK;
        default: op = OP_STOP;
      endcase
    end else begin
      unique case (idx)
        4'd0:    op = OP_START;
        4'd1:    op = OP_SDEV;
        4'd2:    op = OP_ACK;
        4'd3:    op = OP_SREG;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_START;
        4'd6:    op = OP_SDEV1;
        4'd7:    op = OP_ACK;
        4'd8:    op = OP_READ;
        4'd9:    op = OP_NACK;
        default: op = OP_STOP;
      endcase
    end
    return op;
  endfunction

  phase_t     phase_r, phase_nxt;
  logic [7:0] delay_r, delay_nxt;
  logic [3:0] bitc_r, bitc_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       op_wr_r, op_wr_nxt;
  logic [7:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic [7:0] data_r, data_nxt;
  logic [7:0] rdres_r, rdres_nxt;
  logic       err_r, err_nxt;
  logic [3:0] step_r, step_nxt;

  phase_t     ph;
  logic [7:0] dly;
  logic       expired;
  logic       op_go;
  logic       step_go;
  op_t        op_sel;
  logic [3:0] bitc_inc;
  logic [7:0] rd_shift;
  logic       scl, sda, drv, done, busy;

  // Next-state and tick output logic.
  always_comb begin
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    bitc_nxt  = bitc_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    op_wr_nxt = op_wr_r;
    dev_nxt   = dev_r;
    reg_nxt   = reg_r;
    data_nxt  = data_r;
    rdres_nxt = rdres_r;
    err_nxt   = err_r;
    step_nxt  = step_r;
    scl       = 1'b1;
    sda       = 1'b1;
    drv       = 1'b1;
    done      = 1'b0;
    op_go     = 1'b0;
    step_go   = 1'b0;
    op_sel    = OP_STOP;
    // An undefined phase code counts as idle.
    ph        = (phase_r > PH_STOP_END) ? PH_IDLE : phase_r;
    dly       = delay_r;
    bitc_inc  = bitc_r + 4'd1;
    rd_shift  = {shift_r[6:0], item.sda_in};

    // A request taken while idle is already the first start tick.
    if (step_en && (ph == PH_IDLE) && item.req) begin
      op_wr_nxt = item.func;
      dev_nxt   = item.dev_addr;
      reg_nxt   = item.mem_addr;
      data_nxt  = item.wr_data;
      err_nxt   = 1'b0;
      step_nxt  = 4'd0;
      ph        = PH_START_A;
      dly       = cfg.start_stop_delay;
    end
    busy      = (ph != PH_IDLE) && (ph != PH_STOP_END);
    phase_nxt = ph;
    delay_nxt = dly;
    expired   = (dly <= 8'd1);

    unique case (ph)
      PH_START_A: begin
        if (expired) begin
          phase_nxt = PH_START_B;
          delay_nxt = cfg.start_stop_delay;
        end else delay_nxt = dly - 8'd1;
      end
      PH_START_B: begin
        sda = 1'b0;
        if (expired) step_go = 1'b1;
        else delay_nxt = dly - 8'd1;
      end
      PH_SEND_LO: begin
        scl = 1'b0;
        sda = shift_r[7];
        if (expired) begin
          phase_nxt = PH_SEND_HI;
          delay_nxt = cfg.bit_phase_delay;
        end else delay_nxt = dly - 8'd1;
      end
      PH_SEND_HI: begin
        sda = shift_r[7];
        if (expired) begin
          phase_nxt = PH_SEND_TAIL;
          delay_nxt = cfg.bit_phase_delay;
        end else delay_nxt = dly - 8'd1;
      end
      PH_SEND_TAIL: begin
        scl = 1'b0;
        sda = shift_r[7];
        if (expired) begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bitc_nxt  = bitc_inc;
          if (bitc_inc >= 4'd8) step_go = 1'b1;
          else begin
            phase_nxt = PH_SEND_LO;
            delay_nxt = cfg.bit_phase_delay;
          end
        end else delay_nxt = dly - 8'd1;
      end
      PH_ACK_PREP: begin
        scl       = 1'b0;
        phase_nxt = PH_ACK_HI;
        delay_nxt = 8'd1;
      end
      PH_ACK_HI: begin
        drv       = 1'b0;
        phase_nxt = PH_ACK_POLL;
        delay_nxt = 8'd1;
      end
      PH_ACK_POLL: begin
        drv = 1'b0;
        if (!item.sda_in) step_go = 1'b1;
        else if (poll_r >= cfg.ack_limit) begin
          // Timeout: flag it and go straight to stop.
          err_nxt = 1'b1;
          op_go   = 1'b1;
          op_sel  = OP_STOP;
        end else poll_nxt = poll_r + 8'd1;
      end
      PH_READ_LO: begin
        scl = 1'b0;
        drv = 1'b0;
        if (expired) begin
          phase_nxt = PH_READ_HI;
          delay_nxt = 8'd1;
        end else delay_nxt = dly - 8'd1;
      end
      PH_READ_HI: begin
        drv       = 1'b0;
        shift_nxt = rd_shift;
        bitc_nxt  = bitc_inc;
        if (bitc_inc >= 4'd8) begin
          rdres_nxt = rd_shift;
          step_go   = 1'b1;
        end else begin
          phase_nxt = PH_READ_LO;
          delay_nxt = cfg.bit_phase_delay;
        end
      end
      PH_NACK_LO: begin
        scl = 1'b0;
        if (expired) begin
          phase_nxt = PH_NACK_HI;
          delay_nxt = cfg.bit_phase_delay;
        end else delay_nxt = dly - 8'd1;
      end
      PH_NACK_HI: begin
        if (expired) step_go = 1'b1;
        else delay_nxt = dly - 8'd1;
      end
      PH_STOP_A: begin
        scl = 1'b0;
        sda = 1'b0;
        if (expired) begin
          phase_nxt = PH_STOP_END;
          delay_nxt = 8'd1;
        end else delay_nxt = dly - 8'd1;
      end
      PH_STOP_END: begin
        done      = 1'b1;
        phase_nxt = PH_IDLE;
        delay_nxt = 8'd0;
      end
      default: begin
        // Idle, and any undefined code, keep the bus released high.
        phase_nxt = PH_IDLE;
      end
    endcase

    // Move to the next script step.
    if (step_go) begin
      step_nxt = step_r + 4'd1;
      op_go    = 1'b1;
      op_sel   = script_op(op_wr_r, step_nxt);
    end

    // Set up the phase that opens the selected operation.
    if (op_go) begin
      unique case (op_sel)
        OP_START: begin
          phase_nxt = PH_START_A;
          delay_nxt = cfg.start_stop_delay;
        end
        OP_SDEV, OP_SREG, OP_SDATA, OP_SDEV1: begin
          unique case (op_sel)
            OP_SDEV:  shift_nxt = dev_r;
            OP_SREG:  shift_nxt = reg_r;
            OP_SDATA: shift_nxt = data_r;
            default:  shift_nxt = dev_r + 8'd1;
          endcase
          bitc_nxt  = 4'd0;
          phase_nxt = PH_SEND_LO;
          delay_nxt = cfg.bit_phase_delay;
        end
        OP_ACK: begin
          phase_nxt = PH_ACK_PREP;
          delay_nxt = 8'd1;
          poll_nxt  = 8'd0;
        end
        OP_READ: begin
          shift_nxt = 8'd0;
          bitc_nxt  = 4'd0;
          phase_nxt = PH_READ_LO;
          delay_nxt = cfg.bit_phase_delay;
        end
        OP_NACK: begin
          phase_nxt = PH_NACK_LO;
          delay_nxt = cfg.bit_phase_delay;
        end
        default: begin
          phase_nxt = PH_STOP_A;
          delay_nxt = cfg.start_stop_delay;
        end
      endcase
    end

    if (!drv) sda = 1'b1;

    res.scl_out   = scl;
    res.sda_out   = sda;
    res.sda_drive = drv;
    res.busy_res  = busy;
    res.done_res  = done;
    res.rd_data   = rdres_nxt;
    res.ack_error = err_nxt;
  end

  // State registers, updated once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      delay_r <= 8'd0;
      bitc_r  <= 4'd0;
      shift_r <= 8'd0;
      poll_r  <= 8'd0;
      op_wr_r <= 1'b0;
      dev_r   <= 8'd0;
      reg_r   <= 8'd0;
      data_r  <= 8'd0;
      rdres_r <= 8'd0;
      err_r   <= 1'b0;
      step_r  <= 4'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
      bitc_r  <= bitc_nxt;
      shift_r <= shift_nxt;
      poll_r  <= poll_nxt;
      op_wr_r <= op_wr_nxt;
      dev_r   <= dev_nxt;
      reg_r   <= reg_nxt;
      data_r  <= data_nxt;
      rdres_r <= rdres_nxt;
      err_r   <= err_nxt;
      step_r  <= step_nxt;
    end
  end

  // The sequencer only moves when an item is processed.
  a_hold_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(step_r) && $stable(rdres_r))
    else $error("engine state changed without an item");

  // The stop tick always returns to idle.
  a_stop_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (phase_r == PH_STOP_END) |=> phase_r == PH_IDLE)
    else $error("stop end did not return to idle");

  // The finishing tick is never reported as busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done_res |-> !res.busy_res && (phase_r == PH_STOP_END))
    else $error("done reported while busy");

endmodule

FILE: hw/rtl/i2c_master_register_access_core.sv
// Top level of the I2C single-byte register read/write master.
//
// Usage: every input item is one bus tick (typically one microsecond). An
// item carries a request (req, func, dev_addr, mem_addr, wr_data) and the
// sampled SDA level. A request is taken only while the master is idle and
// then runs a register write or a register read script on the bus. For
// each item the block returns one result item with the SCL/SDA levels and
// SDA drive enable for that tick, busy and done flags, the last read byte
// and the ACK timeout flag.
// Throughput is one item per clock while out_tready stays high; an item
// passes the input register and then the result register, and the whole
// tick update sits between those two registers.
// When the receiver stalls, the result register holds and the input
// register fills; in_tready drops only once both are occupied.
// The cfg channel writes start_stop_delay (0), bit_phase_delay (1) and
// ack_limit (2); it is always ready. Write it only while the bus is idle;
// the block does not enforce this. Reset returns the delays to 4, 2 and 250,
// idles the bus high, clears the read byte and error flag and empties both registers.
module i2c_master_register_access_core
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: req[0], func[1], dev_addr[9:2], mem_addr[17:10],
  //           wr_data[25:18], sda_in[26], zero[31:27]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out_tdata: scl_out[0], sda_out[1], sda_drive[2], busy_res[3],
  //            done_res[4], rd_data[12:5], ack_error[13], zero[15:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t  cfg_r;
  item_t item_r;
  logic  in_valid_r;
  res_t  res_r;
  logic  out_valid_r;
  res_t  res_now;
  logic  advance;
  logic  step_en;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign step_en    = in_valid_r && advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_stop_delay <= 8'd4;
      cfg_r.bit_phase_delay  <= 8'd2;
      cfg_r.ack_limit        <= 8'd250;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgStartStop: cfg_r.start_stop_delay <= cfg_data;
        CfgBitPhase:  cfg_r.bit_phase_delay  <= cfg_data;
        CfgAckLimit:  cfg_r.ack_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_tdata[ItemW-1:0];
    end
  end

  i2cm_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res_now)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_now;
    end
  end

  // A waiting item in the input register is kept while the output stalls.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r))
    else $error("buffered item lost during stall");

  // A processed item always shows up in the result register.
  a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_valid_r)
    else $error("processed item did not reach the result register");

  // A result item that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(res_r))
    else $error("stalled result item changed");

endmodule

FILE: tb/sv/i2cm_tick_checker.sv
`timescale 1ns / 1ps
// Function codes plus the checker that predicts and compares bus ticks.
package i2cm_tb_pkg;

  localparam logic FuncRead  = 1'b0;
  localparam logic FuncWrite = 1'b1;

endpackage

module i2cm_tick_checker
  import i2cm_pkg::*;
  import i2cm_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          pending,
  output logic        bus_idle
);

  typedef enum logic [4:0] {
    PhIdle, PhStartA, PhStartB, PhSendLo, PhSendHi, PhSendTail, PhAckPrep, PhAckHi,
    PhAckPoll, PhReadLo, PhReadHi, PhNackLo, PhNackHi, PhStopA, PhStopEnd
  } phase_t;

  typedef enum logic [3:0] {
    OpStart, OpSendDev, OpSendReg, OpSendData, OpSendDevRd, OpAck, OpRead, OpNack, OpStop
  } bus_op_t;

  // Timing registers as the block should hold them.
  logic [7:0] ss_dly, bit_dly, ack_lim;

  // Predicted engine state.
  phase_t     ph;
  logic [7:0] dcnt, shreg, pcnt;
  logic [3:0] bcnt, step_idx;
  logic       is_write, err_q;
  logic [7:0] dev_q, reg_q, data_q, rd_byte;

  res_t bus_ticks_due[$];
  res_t got_tick, want_tick;
  int   bad_fields = 0;

  function automatic void reset_engine();
    ss_dly = 8'd4;
    bit_dly = 8'd2;
    ack_lim = 8'd250;
    ph = PhIdle;
    dcnt = '0;
    bcnt = '0;
    shreg = '0;
    pcnt = '0;
    step_idx = '0;
    is_write = 1'b0;
    dev_q = '0;
    reg_q = '0;
    data_q = '0;
    rd_byte = '0;
    err_q = 1'b0;
  endfunction

  // Fixed sequence of bus operations for a register write or read.
  function automatic bus_op_t script_op(logic wr, logic [3:0] idx);
    bus_op_t op;
    op = OpStop;
    if (wr) begin
      case (idx)
        4'd0: op = OpStart;
        4'd1: op = OpSendDev;
        4'd2: op = OpAck;
        4'd3: op = OpSendReg;
        4'd4: op = OpAck;
        4'd5: op = OpSendData;
        4'd6: op = OpAck;
        default: op = OpStop;
      endcase
    end else begin
      case (idx)
        4'd0: op = OpStart;
        4'd1: op = OpSendDev;
        4'd2: op = OpAck;
        4'd3: op = OpSendReg;
        4'd4: op = OpAck;
        4'd5: op = OpStart;
        4'd6: op = OpSendDevRd;
        4'd7: op = OpAck;
        4'd8: op = OpRead;
        4'd9: op = OpNack;
        default: op = OpStop;
      endcase
    end
    return op;
  endfunction

  function automatic void goto_phase(phase_t p, logic [7:0] d);
    ph = p;
    dcnt = d;
  endfunction

  function automatic void load_byte(logic [7:0] b);
    shreg = b;
    bcnt = '0;
    goto_phase(PhSendLo, bit_dly);
  endfunction

  function automatic void begin_op(bus_op_t op);
    case (op)
      OpStart:     goto_phase(PhStartA, ss_dly);
      OpSendDev:   load_byte(dev_q);
      OpSendReg:   load_byte(reg_q);
      OpSendData:  load_byte(data_q);
      OpSendDevRd: load_byte(dev_q + 8'd1);
      OpAck: begin
        goto_phase(PhAckPrep, 8'd1);
        pcnt = '0;
      end
      OpRead: begin
        shreg = '0;
        bcnt = '0;
        goto_phase(PhReadLo, bit_dly);
      end
      OpNack:      goto_phase(PhNackLo, bit_dly);
      default:     goto_phase(PhStopA, ss_dly);
    endcase
  endfunction

  function automatic void next_op();
    step_idx = step_idx + 4'd1;
    begin_op(script_op(is_write, step_idx));
  endfunction

  // A hold count of zero behaves like one.
  function automatic logic delay_done();
    if (dcnt <= 8'd1) return 1'b1;
    dcnt = dcnt - 8'd1;
    return 1'b0;
  endfunction

  // Advance the engine by one bus tick and return the levels it drives.
  function automatic res_t step_bus(item_t it);
    res_t r;
    logic scl, sda, drv, fin, busy;
    scl = 1'b1;
    sda = 1'b1;
    drv = 1'b1;
    fin = 1'b0;
    if (ph == PhIdle && it.req) begin
      is_write = it.func;
      dev_q = it.dev_addr;
      reg_q = it.mem_addr;
      data_q = it.wr_data;
      err_q = 1'b0;
      step_idx = '0;
      begin_op(OpStart);
    end
    busy = (ph != PhIdle && ph != PhStopEnd);

    case (ph)
      PhStartA: if (delay_done()) goto_phase(PhStartB, ss_dly);
      PhStartB: begin
        sda = 1'b0;
        if (delay_done()) next_op();
      end
      PhSendLo: begin
        scl = 1'b0;
        sda = shreg[7];
        if (delay_done()) goto_phase(PhSendHi, bit_dly);
      end
      PhSendHi: begin
        sda = shreg[7];
        if (delay_done()) goto_phase(PhSendTail, bit_dly);
      end
      PhSendTail: begin
        scl = 1'b0;
        sda = shreg[7];
        if (delay_done()) begin
          shreg = shreg << 1;
          bcnt = bcnt + 4'd1;
          if (bcnt >= 4'd8) next_op();
          else goto_phase(PhSendLo, bit_dly);
        end
      end
      PhAckPrep: begin
        scl = 1'b0;
        goto_phase(PhAckHi, 8'd1);
      end
      PhAckHi: begin
        drv = 1'b0;
        goto_phase(PhAckPoll, 8'd1);
      end
      PhAckPoll: begin
        drv = 1'b0;
        // A poll that fails once the limit is used up aborts with a stop.
        if (!it.sda_in) begin
          next_op();
        end else if (pcnt >= ack_lim) begin
          err_q = 1'b1;
          begin_op(OpStop);
        end else begin
          pcnt = pcnt + 8'd1;
        end
      end
      PhReadLo: begin
        scl = 1'b0;
        drv = 1'b0;
        if (delay_done()) goto_phase(PhReadHi, 8'd1);
      end
      PhReadHi: begin
        drv = 1'b0;
        shreg = {shreg[6:0], it.sda_in};
        bcnt = bcnt + 4'd1;
        if (bcnt >= 4'd8) begin
          rd_byte = shreg;
          next_op();
        end else begin
          goto_phase(PhReadLo, bit_dly);
        end
      end
      PhNackLo: begin
        scl = 1'b0;
        if (delay_done()) goto_phase(PhNackHi, bit_dly);
      end
      PhNackHi: if (delay_done()) next_op();
      PhStopA: begin
        scl = 1'b0;
        sda = 1'b0;
        if (delay_done()) goto_phase(PhStopEnd, 8'd1);
      end
      PhStopEnd: begin
        fin = 1'b1;
        goto_phase(PhIdle, 8'd0);
      end
      default: ;
    endcase

    if (!drv) sda = 1'b1;
    r.scl_out = scl;
    r.sda_out = sda;
    r.sda_drive = drv;
    r.busy_res = busy;
    r.done_res = fin;
    r.rd_data = rd_byte;
    r.ack_error = err_q;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      bad_fields++;
    end
  endfunction

  // Track register writes, compare each result item, then predict each new input item.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_engine();
      bus_ticks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgStartStop: ss_dly = cfg_data;
          CfgBitPhase:  bit_dly = cfg_data;
          CfgAckLimit:  ack_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got_tick = out_tdata[ResW-1:0];
        if (bus_ticks_due.size() == 0) begin
          $display("%0t: result item 0x%0h arrived with none expected", $time, got_tick);
          bad_fields++;
        end else begin
          want_tick = bus_ticks_due.pop_front();
          check_field("scl_out", want_tick.scl_out, got_tick.scl_out);
          check_field("sda_out", want_tick.sda_out, got_tick.sda_out);
          check_field("sda_drive", want_tick.sda_drive, got_tick.sda_drive);
          check_field("busy_res", want_tick.busy_res, got_tick.busy_res);
          check_field("done_res", want_tick.done_res, got_tick.done_res);
          check_field("rd_data", want_tick.rd_data, got_tick.rd_data);
          check_field("ack_error", want_tick.ack_error, got_tick.ack_error);
        end
      end
      if (in_tvalid && in_tready) begin
        bus_ticks_due.push_back(step_bus(in_tdata[ItemW-1:0]));
      end
    end
    mismatches <= bad_fields;
    pending <= bus_ticks_due.size();
    bus_idle <= (ph == PhIdle);
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the I2C master testbench: clock, reset, bus tick stimulus and the verdict.
module testbench;
  import i2cm_pkg::*;
  import i2cm_tb_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseTicks  = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int          mismatches;
  int          pending;
  logic        bus_idle;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned ticks_sent = 0;
  int unsigned quiet_cycles = 0;

  i2c_master_register_access_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  i2cm_tick_checker i_tick_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .bus_idle   (bus_idle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random with the current percentage.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Give up when no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic item_t rand_item(int unsigned req_pct, int unsigned sda_low_pct);
    item_t it;
    it.req = ($urandom_range(99) < req_pct);
    it.func = 1'($urandom_range(1));
    it.dev_addr = 8'($urandom_range(255));
    it.mem_addr = 8'($urandom_range(255));
    it.wr_data = 8'($urandom_range(255));
    it.sda_in = !($urandom_range(99) < sda_low_pct);
    return it;
  endfunction

  function automatic item_t req_item(logic fn, logic [7:0] dev, logic [7:0] mem,
                                     logic [7:0] wdata);
    item_t it;
    it.req = 1'b1;
    it.func = fn;
    it.dev_addr = dev;
    it.mem_addr = mem;
    it.wr_data = wdata;
    it.sda_in = 1'b0;
    return it;
  endfunction

  // Present one bus tick, after an optional random gap, and wait for it to be taken.
  task automatic send_tick(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= 32'(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // Start a transaction and keep ticking until the bus is predicted idle again.
  task automatic run_xfer(item_t first, int unsigned busy_req_pct, int unsigned sda_low_pct);
    first.req = 1'b1;
    send_tick(first);
    do send_tick(rand_item(busy_req_pct, sda_low_pct)); while (!bus_idle);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Retime the bus only once the engine is idle and every result item is back.
  task automatic set_timing(logic [7:0] ss, logic [7:0] bp, logic [7:0] lim);
    do send_tick(rand_item(0, 50)); while (!bus_idle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    write_reg(CfgStartStop, ss);
    write_reg(CfgBitPhase, bp);
    write_reg(CfgAckLimit, lim);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned stall);
    int unsigned first_tick;
    int unsigned sda_low;
    int unsigned busy_req;
    set_timing(8'($urandom_range(0, 2)), 8'($urandom_range(0, 1)),
               ($urandom_range(3) == 0) ? 8'd250 : 8'($urandom_range(0, 6)));
    send_idle_pct = idle_pct;
    stall_pct = stall;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < PhaseTicks) begin
      case ($urandom_range(3))
        0: sda_low = 5;
        1: sda_low = 30;
        2: sda_low = 70;
        default: sda_low = 95;
      endcase
      case ($urandom_range(3))
        0: busy_req = 20;
        1: busy_req = 100;
        default: busy_req = 0;
      endcase
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 5)) send_tick(rand_item(0, 50));
        1: repeat ($urandom_range(1, 8)) send_tick(rand_item(30, sda_low));
        default: run_xfer(rand_item(100, sda_low), busy_req, sda_low);
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: a read whose second device byte wraps to zero.
    run_xfer(req_item(FuncRead, 8'hFF, 8'hFF, 8'h00), 0, 50);

    // Zero delays act as one; a zero ack limit aborts on the first failed poll.
    set_timing(8'd0, 8'd0, 8'd0);
    run_xfer(req_item(FuncWrite, 8'hA5, 8'h5A, 8'hC3), 0, 0);

    // Requests held high, so some land on the finishing tick and while busy;
    // the new transaction also clears the error flag.
    set_timing(8'd1, 8'd1, 8'd3);
    run_xfer(req_item(FuncWrite, 8'h42, 8'h24, 8'hAA), 100, 80);

    // Random transactions under each idling pattern.
    random_phase(0, 0);
    random_phase(68, 0);
    random_phase(0, 68);
    random_phase(12, 12);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
